### sv/fmss_pkg.sv
// Shared types and constants for the first-match string search block.
// Used by fmss_cell and first_match_string_search_top; no dependencies.

package fmss_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 16;

  // Text counter saturates here; bytes beyond it are ignored
  localparam logic [POS_W-1:0] TEXT_LIMIT = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } op_e;

  // Broadcast to every cell of the chain each cycle
  typedef struct packed {
    logic              append;
    logic              clear_pat;
    logic              clear_text;
    logic              text_en;
    logic [BYTE_W-1:0] data;
  } cell_ctrl_t;

endpackage

### sv/fmss_cell.sv
// One pattern position of the search chain: pattern byte, occupancy and alignment bit.
// Depends on fmss_pkg for the broadcast control struct.

module fmss_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fmss_pkg::cell_ctrl_t ctrl_i,
  input  logic                 align_prev_i,
  input  logic                 active_prev_i,
  input  logic                 active_next_i,
  output logic                 active_o,
  output logic                 align_o,
  output logic                 last_o,
  output logic                 hit_o
);

  logic                        active_q, active_d;
  logic                        align_q, align_d;
  logic [fmss_pkg::BYTE_W-1:0] pat_q;
  logic                        free_slot;
  logic                        match_new;

  // Next free position: neighbour below occupied, this one not
  assign free_slot = active_prev_i & ~active_q;
  assign match_new = align_prev_i & (pat_q == ctrl_i.data);

  always_comb begin
    active_d = active_q;
    if (ctrl_i.clear_pat) begin
      active_d = 1'b0;
    end else if (ctrl_i.append && free_slot) begin
      active_d = 1'b1;
    end
  end

  always_comb begin
    align_d = align_q;
    if (ctrl_i.clear_text) begin
      align_d = 1'b0;
    end else if (ctrl_i.append && free_slot) begin
      align_d = 1'b0;
    end else if (ctrl_i.text_en && active_q) begin
      align_d = match_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      align_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      align_q  <= align_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.append && free_slot) begin
      pat_q <= ctrl_i.data;
    end
  end

  assign active_o = active_q;
  assign last_o   = active_q & ~active_next_i;
  assign hit_o    = last_o & ctrl_i.text_en & match_new;

  // The outgoing alignment bit feeds the next cell's compare
  assign align_o  = align_q;

endmodule

### sv/first_match_string_search_top.sv
// First-match string search: top level with the cell chain, counters and result register.
// Depends on fmss_pkg and fmss_cell.
// Throughput: one item per cycle; an end-of-text item waits only while a result is held and not taken.
// Latency: the result is valid in the cycle after the end-of-text transfer.
// Reset clears pattern length, occupancy, alignment bits, text state and result valid;
// pattern bytes and the result payload are not reset and are only read once written.

module first_match_string_search_top #(
  parameter int unsigned PATTERN_MAX = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  opcode_i,
  input  logic [fmss_pkg::BYTE_W-1:0] data_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [fmss_pkg::POS_W-1:0]  position_o
);

  localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);

  fmss_pkg::cell_ctrl_t           ctrl;
  logic                           in_fire;
  logic                           is_append, is_clear, is_text, is_end;
  logic                           text_take;
  logic [PATTERN_MAX-1:0]         active, last, hit, align_chain;

  logic [LEN_W-1:0]               len_q, len_d;
  logic [fmss_pkg::POS_W-1:0]     cnt_q, cnt_d;
  logic                           seen_q, seen_d;
  logic [fmss_pkg::POS_W-1:0]     first_q, first_d;
  logic                           out_valid_q, out_valid_d;
  logic                           found_q, found_d;
  logic [fmss_pkg::POS_W-1:0]     pos_q, pos_d;
  logic [fmss_pkg::POS_W-1:0]     match_start;

  // Result slot only needed for end-of-text items
  assign in_ready_o = out_ready_i | ~out_valid_q |
                      (opcode_i != fmss_pkg::OP_END);
  assign in_fire    = in_valid_i & in_ready_o;

  assign is_append = in_fire & (opcode_i == fmss_pkg::OP_APPEND);
  assign is_clear  = in_fire & (opcode_i == fmss_pkg::OP_CLEAR);
  assign is_text   = in_fire & (opcode_i == fmss_pkg::OP_TEXT);
  assign is_end    = in_fire & (opcode_i == fmss_pkg::OP_END);
  assign text_take = is_text & (cnt_q != fmss_pkg::TEXT_LIMIT);

  always_comb begin
    ctrl.append     = is_append;
    ctrl.clear_pat  = is_clear;
    ctrl.clear_text = is_clear | is_end;
    ctrl.text_en    = text_take;
    ctrl.data       = data_byte_i;
  end

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    logic align_prev, active_prev, active_next;
    if (j == 0) begin : g_head
      assign align_prev  = 1'b1;
      assign active_prev = 1'b1;
    end else begin : g_body
      assign align_prev  = align_chain[j-1];
      assign active_prev = active[j-1];
    end
    if (j == PATTERN_MAX - 1) begin : g_tail
      assign active_next = 1'b0;
    end else begin : g_mid
      assign active_next = active[j+1];
    end

    fmss_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .align_prev_i  (align_prev),
      .active_prev_i (active_prev),
      .active_next_i (active_next),
      .active_o      (active[j]),
      .align_o       (align_chain[j]),
      .last_o        (last[j]),
      .hit_o         (hit[j])
    );
  end

  assign match_start = cnt_q + 16'd1 - {{(fmss_pkg::POS_W-LEN_W){1'b0}}, len_q};

  always_comb begin
    len_d   = len_q;
    cnt_d   = cnt_q;
    seen_d  = seen_q;
    first_d = first_q;
    if (is_clear) begin
      len_d   = '0;
      cnt_d   = '0;
      seen_d  = 1'b0;
      first_d = '0;
    end else if (is_end) begin
      cnt_d   = '0;
      seen_d  = 1'b0;
      first_d = '0;
    end else if (is_append) begin
      if (len_q != LEN_W'(PATTERN_MAX)) begin
        len_d = len_q + 1'b1;
      end
    end else if (text_take) begin
      cnt_d = cnt_q + 1'b1;
      if (!seen_q && (|hit)) begin
        seen_d  = 1'b1;
        first_d = match_start;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    found_d     = found_q;
    pos_d       = pos_q;
    if (is_end) begin
      out_valid_d = 1'b1;
      found_d     = (len_q == '0) | seen_q;
      pos_d       = ((len_q != '0) && seen_q) ? first_q : '0;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      cnt_q       <= '0;
      seen_q      <= 1'b0;
      first_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      seen_q      <= seen_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    pos_q   <= pos_d;
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign position_o  = pos_q;

  // Occupied cells always form a prefix whose size is the pattern length
  a_len_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(active) == int'(len_q))
    else $error("pattern length and occupied cells disagree");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(last) && ((len_q == '0) == (last == '0)))
    else $error("last-cell marker inconsistent");

  a_result_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_end |=> out_valid_o)
    else $error("end-of-text transfer gave no result");

  a_first_only_when_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> (first_q == '0))
    else $error("start position held without a match");

  a_hit_only_on_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|hit) |-> text_take)
    else $error("match reported outside a text transfer");

endmodule

### tb/sv/tb_first_match_string_search_top.sv
// Self-checking bench for first_match_string_search_top: directed and random searches.
// Keeps its own shift-and search state to predict each end-of-text result.
// Depends on fmss_pkg and the block's RTL only.

module tb_first_match_string_search_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SEARCH_CAP  = 64;
  localparam int unsigned QUIET_LIMIT = 5000;

  typedef struct packed {
    logic                       found;
    logic [fmss_pkg::POS_W-1:0] position;
  } search_result_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic [1:0]                  opcode_i    = fmss_pkg::OP_CLEAR;
  logic [fmss_pkg::BYTE_W-1:0] data_byte_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic                        found_o;
  logic [fmss_pkg::POS_W-1:0]  position_o;

  // search state as the bench sees it
  logic [fmss_pkg::BYTE_W-1:0] pat_bytes [SEARCH_CAP];
  int unsigned                 pat_len;
  logic [SEARCH_CAP-1:0]       live_align;
  logic [fmss_pkg::POS_W-1:0]  text_taken;
  logic                        match_seen;
  logic [fmss_pkg::POS_W-1:0]  first_pos;

  search_result_t    expected_results [$];
  search_result_t    oldest_result;
  int unsigned       mismatch_count = 0;
  int unsigned       items_sent = 0;
  bit                stall_on = 1'b0;
  int unsigned       hold_len = 0;

  first_match_string_search_top #(
    .PATTERN_MAX(SEARCH_CAP)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .data_byte_i(data_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .found_o    (found_o),
    .position_o (position_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_text_state();
    live_align = '0;
    text_taken = '0;
    match_seen = 1'b0;
    first_pos  = '0;
  endfunction

  function automatic void predict_search(fmss_pkg::op_e op, logic [fmss_pkg::BYTE_W-1:0] b);
    logic [SEARCH_CAP-1:0] eq;
    search_result_t        r;
    case (op)
      fmss_pkg::OP_APPEND: begin
        if (pat_len < SEARCH_CAP) begin
          pat_bytes[pat_len]  = b;
          live_align[pat_len] = 1'b0;
          pat_len++;
        end
      end
      fmss_pkg::OP_CLEAR: begin
        pat_len = 0;
        clear_text_state();
      end
      fmss_pkg::OP_TEXT: begin
        if (text_taken != fmss_pkg::TEXT_LIMIT) begin
          if (pat_len != 0) begin
            for (int j = 0; j < SEARCH_CAP; j++)
              eq[j] = (j < int'(pat_len)) && (pat_bytes[j] == b);
            // shift-and: bit j survives if bit j-1 was live and byte j matches
            live_align = {live_align[SEARCH_CAP-2:0], 1'b1} & eq;
            if (!match_seen && live_align[pat_len-1]) begin
              match_seen = 1'b1;
              first_pos  = text_taken + fmss_pkg::POS_W'(1) - fmss_pkg::POS_W'(pat_len);
            end
          end
          text_taken++;
        end
      end
      default: begin
        if (pat_len == 0) r = '{found: 1'b1, position: '0};
        else if (match_seen) r = '{found: 1'b1, position: first_pos};
        else r = '{found: 1'b0, position: '0};
        expected_results.push_back(r);
        clear_text_state();
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
    mismatch_count++;
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // one input transfer; valid stays up afterwards so back-to-back items need no gap
  task automatic push_item(fmss_pkg::op_e op, logic [fmss_pkg::BYTE_W-1:0] b);
    if (stall_on && $urandom_range(0, 5) == 0) begin
      release_input();
      repeat ($urandom_range(0, 16)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predict_search(op, b);
    items_sent++;
  endtask

  task automatic wait_drained();
    release_input();
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_len != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_len - 1) @(negedge clk_i);
        hold_len = 0;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", 0, 1);
      end else begin
        oldest_result = expected_results.pop_front();
        if (found_o !== oldest_result.found)
          report_mismatch("found", 32'(oldest_result.found), 32'(found_o));
        if (position_o !== oldest_result.position)
          report_mismatch("position", 32'(oldest_result.position), 32'(position_o));
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic test_empty_pattern();
    push_item(fmss_pkg::OP_END, 8'h00);
    push_item(fmss_pkg::OP_TEXT, 8'h00);
    push_item(fmss_pkg::OP_TEXT, 8'hFF);
    push_item(fmss_pkg::OP_END, 8'hFF);
  endtask

  task automatic test_basic_matches();
    push_item(fmss_pkg::OP_CLEAR, 8'hA5);
    push_item(fmss_pkg::OP_APPEND, 8'h61);
    push_item(fmss_pkg::OP_APPEND, 8'h62);
    push_item(fmss_pkg::OP_TEXT, 8'h78);
    push_item(fmss_pkg::OP_TEXT, 8'h61);
    push_item(fmss_pkg::OP_TEXT, 8'h62);
    push_item(fmss_pkg::OP_TEXT, 8'h61);
    push_item(fmss_pkg::OP_TEXT, 8'h62);
    push_item(fmss_pkg::OP_END, 8'h5A);
    // pattern longer than the text
    push_item(fmss_pkg::OP_APPEND, 8'h63);
    push_item(fmss_pkg::OP_TEXT, 8'h61);
    push_item(fmss_pkg::OP_TEXT, 8'h62);
    push_item(fmss_pkg::OP_END, 8'h00);
    // pattern grows mid-text; earlier match is kept
    push_item(fmss_pkg::OP_CLEAR, 8'h00);
    push_item(fmss_pkg::OP_APPEND, 8'hFF);
    push_item(fmss_pkg::OP_TEXT, 8'h00);
    push_item(fmss_pkg::OP_TEXT, 8'hFF);
    push_item(fmss_pkg::OP_APPEND, 8'h00);
    push_item(fmss_pkg::OP_TEXT, 8'h00);
    push_item(fmss_pkg::OP_END, 8'h00);
    // clear mid-text leaves an empty pattern
    push_item(fmss_pkg::OP_TEXT, 8'hFF);
    push_item(fmss_pkg::OP_CLEAR, 8'hFF);
    push_item(fmss_pkg::OP_END, 8'hFF);
  endtask

  task automatic test_pattern_overflow();
    logic [fmss_pkg::BYTE_W-1:0] pat_copy [$];
    push_item(fmss_pkg::OP_CLEAR, 8'h00);
    repeat (SEARCH_CAP + 3) push_item(fmss_pkg::OP_APPEND, 8'($urandom));
    for (int j = 0; j < SEARCH_CAP; j++) pat_copy.push_back(pat_bytes[j]);
    push_item(fmss_pkg::OP_TEXT, 8'h11);
    foreach (pat_copy[j]) push_item(fmss_pkg::OP_TEXT, pat_copy[j]);
    push_item(fmss_pkg::OP_END, 8'h00);
    // the pattern bytes again as text, short of the last one
    for (int j = 0; j < SEARCH_CAP - 1; j++) push_item(fmss_pkg::OP_TEXT, pat_copy[j]);
    push_item(fmss_pkg::OP_END, 8'h00);
  endtask

  task automatic random_search();
    logic [fmss_pkg::BYTE_W-1:0] pool [4];
    logic [fmss_pkg::BYTE_W-1:0] text_q [$];
    int unsigned                 plen;
    int unsigned                 tlen;
    int unsigned                 at;
    int                          skew;
    foreach (pool[k]) pool[k] = 8'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6))
        push_item(fmss_pkg::op_e'(2'($urandom_range(0, 3))), 8'($urandom));
      return;
    end
    if ($urandom_range(0, 4) != 0) begin
      push_item(fmss_pkg::OP_CLEAR, 8'($urandom));
      case ($urandom_range(0, 15))
        0:       plen = 0;
        1:       plen = $urandom_range(56, SEARCH_CAP + 4);
        default: plen = $urandom_range(1, 6);
      endcase
      repeat (plen) push_item(fmss_pkg::OP_APPEND, pool[$urandom_range(0, 3)]);
    end
    tlen = $urandom_range(0, 24);
    for (int i = 0; i < tlen; i++) text_q.push_back(pool[$urandom_range(0, 3)]);
    if (pat_len != 0 && $urandom_range(0, 2) != 0) begin
      at   = $urandom_range(0, tlen);
      skew = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, pat_len - 1)) : -1;
      for (int j = int'(pat_len) - 1; j >= 0; j--)
        text_q.insert(at, (j == skew) ? ~pat_bytes[j] : pat_bytes[j]);
    end
    foreach (text_q[i]) begin
      if ($urandom_range(0, 120) == 0)
        push_item(fmss_pkg::OP_APPEND, pool[$urandom_range(0, 3)]);
      push_item(fmss_pkg::OP_TEXT, text_q[i]);
    end
    push_item(fmss_pkg::OP_END, 8'($urandom));
  endtask

  task automatic test_random_searches(int unsigned n_items, bit idling);
    int unsigned first_item;
    first_item = items_sent;
    while (items_sent - first_item < n_items) begin
      stall_on = idling && ($urandom_range(0, 3) != 0);
      random_search();
    end
    stall_on = 1'b0;
  endtask

  task automatic test_receiver_hold();
    stall_on = 1'b0;
    push_item(fmss_pkg::OP_CLEAR, 8'h00);
    push_item(fmss_pkg::OP_APPEND, 8'h5A);
    hold_len = 300;
    repeat (40) begin
      push_item(fmss_pkg::OP_TEXT, $urandom_range(0, 1) ? 8'h5A : 8'hA5);
      push_item(fmss_pkg::OP_END, 8'h00);
    end
  endtask

  task automatic test_drain_pause();
    stall_on = 1'b1;
    repeat (5) random_search();
    wait_drained();
    repeat (5) random_search();
    stall_on = 1'b0;
  endtask

  initial begin
    pat_len = 0;
    clear_text_state();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_pattern();
    test_basic_matches();
    test_pattern_overflow();
    test_receiver_hold();
    test_random_searches(800, 1'b1);
    test_drain_pause();
    test_random_searches(250, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
